// File: rtl/smrc_pkg.sv
// smrc_pkg: shared constants for the clockwise square matrix rotator.
// Used by every module of the block; depends on nothing.

package smrc_pkg;

    // Element word and configuration port widths
    localparam int DATA_W   = 32;
    localparam int SIZE_W   = 4;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register map: index taken from paddr[PADDR_W-1:2]
    localparam logic REG_MATRIX_SIZE = 1'b0;

    // Reset value of the side length register
    localparam logic [SIZE_W-1:0] MATRIX_SIZE_RESET = 4'd8;

    // Number of matrix slots (store banks and job queue entries)
    localparam int JOB_SLOTS = 2;

endpackage

// File: rtl/smrc_front.sv
// smrc_front: load side. Counts incoming elements, writes them into the
// current store bank and raises a rotation job when a matrix is complete.
// Depends on smrc_pkg.

module smrc_front #(
    parameter  int MAX_SIDE = 8,
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int SW       = $clog2(MAX_SIDE + 1),
    localparam int JW       = 1 + SW + AW,
    localparam int WW       = 1 + (AW + 1) + smrc_pkg::DATA_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic signed [smrc_pkg::DATA_W-1:0]  i_element_value,
    input  logic [smrc_pkg::SIZE_W-1:0]         i_matrix_size,
    input  logic                                i_job_full,
    output logic                                o_full,
    output logic                                o_job_push,
    output logic [JW-1:0]                       o_job,
    output logic [WW-1:0]                       o_wr
);

    localparam int CW    = $clog2(DEPTH + 1);

    typedef struct packed {
        logic          bank;
        logic [SW-1:0] side;
        logic [AW-1:0] start;
    } t_job;

    typedef struct packed {
        logic                        en;
        logic [AW:0]                 addr;
        logic [smrc_pkg::DATA_W-1:0] data;
    } t_wr;

    logic [CW-1:0] r_count, n_count;
    logic          r_bank,  n_bank;

    logic [SW-1:0] side;
    logic [CW-1:0] side_c;
    logic [CW-1:0] total;
    logic [CW-1:0] cnt_inc;
    logic          accept;
    logic          done;
    t_job          job;
    t_wr           wr;

    // Effective side length: zero reads as one, oversize clamps
    always_comb begin
        if (i_matrix_size == '0) begin
            side = SW'(1);
        end else if (i_matrix_size > smrc_pkg::SIZE_W'(MAX_SIDE)) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = i_matrix_size[SW-1:0];
        end
    end

    assign side_c  = CW'(side);
    assign total   = CW'(side_c * side_c);
    assign cnt_inc = r_count + CW'(1);
    assign accept  = i_push && !o_full;
    assign done    = (cnt_inc >= total);

    // Both banks taken means no room for another matrix
    assign o_full = i_job_full;

    // Store write for the accepted element
    always_comb begin
        wr.en   = accept;
        wr.addr = {r_bank, r_count[AW-1:0]};
        wr.data = i_element_value;
    end
    assign o_wr = wr;

    // Job: bank, side and address of the first element of output row 0
    always_comb begin
        job.bank  = r_bank;
        job.side  = side;
        job.start = AW'((side_c - CW'(1)) * side_c);
    end
    assign o_job      = job;
    assign o_job_push = accept && done;

    // Load counter and bank select
    always_comb begin
        n_count = r_count;
        n_bank  = r_bank;
        if (accept) begin
            if (done) begin
                n_count = '0;
                n_bank  = ~r_bank;
            end else begin
                n_count = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_bank  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_bank  <= n_bank;
        end
    end

endmodule

// File: rtl/smrc_job_fifo.sv
// smrc_job_fifo: two-entry queue of rotation jobs between load and emit.
// Depends on smrc_pkg.

module smrc_job_fifo #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);

    localparam int PW = $clog2(smrc_pkg::JOB_SLOTS);
    localparam int NW = $clog2(smrc_pkg::JOB_SLOTS + 1);

    logic [W-1:0]  r_mem [smrc_pkg::JOB_SLOTS];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == NW'(smrc_pkg::JOB_SLOTS));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

    // Queue level never exceeds its slot count
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(smrc_pkg::JOB_SLOTS))
        else $error("job queue level out of range");

endmodule

// File: rtl/smrc_back.sv
// smrc_back: emit side. Holds the two-bank element store, walks the
// rotated read order for the job at the queue head and buffers results.
// Depends on smrc_pkg.

module smrc_back #(
    parameter  int MAX_SIDE = 8,
    localparam int DEPTH    = MAX_SIDE * MAX_SIDE,
    localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int SW       = $clog2(MAX_SIDE + 1),
    localparam int JW       = 1 + SW + AW,
    localparam int WW       = 1 + (AW + 1) + smrc_pkg::DATA_W
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [WW-1:0]                       i_wr,
    input  logic                                i_job_empty,
    input  logic [JW-1:0]                       i_job,
    output logic                                o_job_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic signed [smrc_pkg::DATA_W-1:0]  o_rotated_value,
    output logic                                o_last_of_matrix
);

    localparam int OUT_DEPTH = 4;
    localparam int OPW       = $clog2(OUT_DEPTH);
    localparam int OCW       = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic          bank;
        logic [SW-1:0] side;
        logic [AW-1:0] start;
    } t_job;

    typedef struct packed {
        logic                        en;
        logic [AW:0]                 addr;
        logic [smrc_pkg::DATA_W-1:0] data;
    } t_wr;

    t_job job;
    t_wr  wr;

    logic [smrc_pkg::DATA_W-1:0] r_store [2 * DEPTH];

    logic                        r_busy;
    logic [SW-1:0]               r_row;
    logic [SW-1:0]               r_col;
    logic [AW-1:0]               r_addr;
    logic [AW-1:0]               r_start;
    logic                        r_rd_vld;
    logic                        r_rd_last;
    logic [smrc_pkg::DATA_W-1:0] r_rd_data;

    logic [smrc_pkg::DATA_W-1:0] r_out_data [OUT_DEPTH];
    logic                        r_out_last [OUT_DEPTH];
    logic [OPW-1:0]              r_out_wr_ptr;
    logic [OPW-1:0]              r_out_rd_ptr;
    logic [OCW-1:0]              r_out_cnt;

    logic [SW-1:0] side_last;
    logic          col_end;
    logic          row_end;
    logic          issue;
    logic          out_pop;

    assign job       = i_job;
    assign wr        = i_wr;
    assign side_last = job.side - SW'(1);
    assign col_end   = (r_col == side_last);
    assign row_end   = (r_row == side_last);

    // Issue a read only when the result buffer has room for it
    assign issue     = r_busy
                    && ((r_out_cnt + OCW'(r_rd_vld)) < OCW'(OUT_DEPTH));
    assign o_job_pop = issue && col_end && row_end;

    // Element store: written by the load side, read in rotated order
    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            r_store[wr.addr] <= wr.data;
        end
        if (issue) begin
            r_rd_data <= r_store[{job.bank, r_addr}];
        end
    end

    // Read address walk: up a column of the loaded matrix per output row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_row     <= '0;
            r_col     <= '0;
            r_addr    <= '0;
            r_start   <= '0;
            r_rd_vld  <= 1'b0;
            r_rd_last <= 1'b0;
        end else begin
            r_rd_vld  <= issue;
            r_rd_last <= o_job_pop;
            if (!r_busy) begin
                if (!i_job_empty) begin
                    r_busy  <= 1'b1;
                    r_row   <= '0;
                    r_col   <= '0;
                    r_addr  <= job.start;
                    r_start <= job.start;
                end
            end else if (issue) begin
                if (col_end) begin
                    r_col <= '0;
                    if (row_end) begin
                        r_busy <= 1'b0;
                    end else begin
                        r_row   <= r_row + SW'(1);
                        r_addr  <= r_start + AW'(1);
                        r_start <= r_start + AW'(1);
                    end
                end else begin
                    r_col  <= r_col + SW'(1);
                    r_addr <= r_addr - AW'(job.side);
                end
            end
        end
    end

    // Result buffer
    assign o_empty          = (r_out_cnt == '0);
    assign out_pop          = i_pop && !o_empty;
    assign o_rotated_value  = r_out_data[r_out_rd_ptr];
    assign o_last_of_matrix = r_out_last[r_out_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_out_data[r_out_wr_ptr] <= r_rd_data;
            r_out_last[r_out_wr_ptr] <= r_rd_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_wr_ptr <= '0;
            r_out_rd_ptr <= '0;
            r_out_cnt    <= '0;
        end else begin
            if (r_rd_vld) begin
                r_out_wr_ptr <= r_out_wr_ptr + OPW'(1);
            end
            if (out_pop) begin
                r_out_rd_ptr <= r_out_rd_ptr + OPW'(1);
            end
            if (r_rd_vld && !out_pop) begin
                r_out_cnt <= r_out_cnt + OCW'(1);
            end else if (out_pop && !r_rd_vld) begin
                r_out_cnt <= r_out_cnt - OCW'(1);
            end
        end
    end

    // Read data in flight always finds a free buffer slot
    a_room_for_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (r_out_cnt < OCW'(OUT_DEPTH)))
        else $error("result buffer overrun");

    // The job being walked stays at the queue head until its last read
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_job_empty)
        else $error("walking a job that left the queue");

    // Retiring a job ends the walk
    a_pop_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_pop |=> !r_busy)
        else $error("walk continues after job retired");

    // The last-of-matrix marker travels with the final read only
    a_last_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_last |-> r_rd_vld)
        else $error("last marker without read data");

endmodule

// File: rtl/square_matrix_rotate_cw.sv
// square_matrix_rotate_cw: top level of the clockwise square matrix rotator.
// Depends on smrc_pkg, smrc_front, smrc_job_fifo and smrc_back.
//
// Usage:
//   Elements of an N by N matrix enter in row-major order on the request
//   channel (push/full, one element per request). N comes from the
//   matrix_size register on the APB port (byte address 0, reset 8; 0 reads
//   as 1, values above MAX_SIDE clamp). When the N*N-th element is taken,
//   the rotated matrix leaves in row-major order on the result channel
//   (empty/pop), the final element marked by o_last_of_matrix.
//   The completing request pushes a job; the walk of the single-read-port
//   element store starts from it and each read passes the read register
//   into the result buffer. Throughput: loading takes one request per cycle
//   while full is low; emitting gives one result per cycle while the result
//   buffer has room, pausing between matrices. Two store banks let the next
//   matrix load while the previous one is emitted; full rises only while
//   both banks hold matrices awaiting emission.
//   Reset clears the load count, bank selects and queues and sets N to 8;
//   the store itself is not cleared. A stalled receiver fills the 4-entry
//   result buffer, halts the store walk, and eventually raises full.

module square_matrix_rotate_cw #(
    parameter int MAX_SIDE = 8
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Element request channel
    input  logic                                 push,
    output logic                                 full,
    input  logic signed [smrc_pkg::DATA_W-1:0]   i_element_value,
    // Result channel
    output logic                                 empty,
    input  logic                                 pop,
    output logic signed [smrc_pkg::DATA_W-1:0]   o_rotated_value,
    output logic                                 o_last_of_matrix,
    // Configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [smrc_pkg::PADDR_W-1:0]         paddr,
    input  logic [smrc_pkg::PDATA_W-1:0]         pwdata,
    output logic [smrc_pkg::PDATA_W-1:0]         prdata,
    output logic                                 pready
);

    localparam int DEPTH = MAX_SIDE * MAX_SIDE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = $clog2(MAX_SIDE + 1);
    localparam int JW    = 1 + SW + AW;
    localparam int WW    = 1 + (AW + 1) + smrc_pkg::DATA_W;

    logic [smrc_pkg::SIZE_W-1:0] r_matrix_size;
    logic                        reg_sel;
    logic                        cfg_wr;

    logic          job_push;
    logic          job_pop;
    logic          job_full;
    logic          job_empty;
    logic [JW-1:0] job_in;
    logic [JW-1:0] job_out;
    logic [WW-1:0] store_wr;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = (paddr[smrc_pkg::PADDR_W-1:2] == smrc_pkg::REG_MATRIX_SIZE);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix_size <= smrc_pkg::MATRIX_SIZE_RESET;
        end else if (cfg_wr) begin
            r_matrix_size <= pwdata[smrc_pkg::SIZE_W-1:0];
        end
    end

    assign prdata = reg_sel ? smrc_pkg::PDATA_W'(r_matrix_size) : '0;

    // Load side
    smrc_front #(
        .MAX_SIDE (MAX_SIDE)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_element_value (i_element_value),
        .i_matrix_size   (r_matrix_size),
        .i_job_full      (job_full),
        .o_full          (full),
        .o_job_push      (job_push),
        .o_job           (job_in),
        .o_wr            (store_wr)
    );

    // Job queue between load and emit
    smrc_job_fifo #(
        .W (JW)
    ) u_job_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_full  (job_full),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    // Emit side
    smrc_back #(
        .MAX_SIDE (MAX_SIDE)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr             (store_wr),
        .i_job_empty      (job_empty),
        .i_job            (job_out),
        .o_job_pop        (job_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_rotated_value  (o_rotated_value),
        .o_last_of_matrix (o_last_of_matrix)
    );

endmodule
